>>> hdl/lj_pkg.sv
package lj_pkg;

  localparam int DIST_W    = 24;
  localparam int CFG_W     = 24;
  localparam int ENERGY_W  = 48;
  localparam int POW_W     = 48;
  localparam int MAG_W     = 49;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WELL_DISTANCE = 1'b0,
    REG_WELL_DEPTH    = 1'b1
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] CFG_RESET = 24'h010000;

  localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
  localparam logic signed [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

  // Flags that travel alongside the arithmetic of one transaction.
  typedef struct packed {
    logic vld;
    logic zero;
    logic ovf;
    logic neg;
  } side_t;

endpackage

>>> hdl/lj_if.sv
interface lj_in_if;
  logic                        valid;
  logic                        ready;
  logic [lj_pkg::DIST_W-1:0]   distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

interface lj_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lj_pkg::ENERGY_W-1:0] energy;
  lj_pkg::status_t                    status;

  modport source (output valid, output energy, output status, input ready);
  modport sink   (input valid, input energy, input status, output ready);
endinterface

>>> hdl/lj_div.sv
// Restoring divider, one quotient bit per pipeline stage.
// Quotient = (rmin << FRAC_BITS) / divisor.
module lj_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [lj_pkg::DIST_W-1:0]             divisor,
  input  logic [lj_pkg::CFG_W-1:0]              rmin,
  output logic [lj_pkg::CFG_W+FRAC_BITS-1:0]    quot
);

  localparam int NW = lj_pkg::CFG_W + FRAC_BITS;
  localparam int RW = lj_pkg::DIST_W;

  logic [RW-1:0] rem_r [NW-1];
  logic [RW-1:0] d_r   [NW-1];
  logic [NW-1:0] quo_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    localparam int BI = NW - 1 - k;

    logic [RW-1:0] rem_in;
    logic [RW-1:0] d_in;
    logic [NW-1:0] quo_in;
    logic          dbit;
    logic [RW:0]   trial;
    logic [RW:0]   trial_sub;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign d_in   = divisor;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign d_in   = d_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    // The dividend is rmin shifted left, so its low FRAC_BITS bits are zero.
    if (BI >= FRAC_BITS) begin : g_dbit
      assign dbit = rmin[BI-FRAC_BITS];
    end else begin : g_zbit
      assign dbit = 1'b0;
    end

    assign trial     = {rem_in, dbit};
    assign trial_sub = trial - {1'b0, d_in};
    assign take      = (trial >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= {quo_in[NW-2:0], take};
      end
    end

    if (k < NW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? trial_sub[RW-1:0] : trial[RW-1:0];
          d_r[k]   <= d_in;
        end
      end
    end
  end

  assign quot = quo_r[NW-1];

endmodule

>>> hdl/lj_mul.sv
// Two-stage multiplier: four partial products, then their sum.
// res is the product shifted right by FRAC_BITS, hi flags bits above res.
module lj_mul #(
  parameter int AW        = 48,
  parameter int BW        = 48,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [AW-1:0]               a,
  input  logic [BW-1:0]               b,
  output logic [lj_pkg::POW_W-1:0]    res,
  output logic                        hi
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;
  localparam int RW = lj_pkg::POW_W;

  logic [AL-1:0]    al;
  logic [AH-1:0]    ah;
  logic [BL-1:0]    bl;
  logic [BH-1:0]    bh;
  logic [AL+BL-1:0] ll_nxt, ll_r;
  logic [AL+BH-1:0] lh_nxt, lh_r;
  logic [AH+BL-1:0] hl_nxt, hl_r;
  logic [AH+BH-1:0] hh_nxt, hh_r;
  logic [PW-1:0]    prod_nxt, prod_r;

  assign al = a[AL-1:0];
  assign ah = a[AW-1:AL];
  assign bl = b[BL-1:0];
  assign bh = b[BW-1:BL];

  assign ll_nxt = al * bl;
  assign lh_nxt = al * bh;
  assign hl_nxt = ah * bl;
  assign hh_nxt = ah * bh;

  assign prod_nxt = PW'(ll_r) + (PW'(lh_r) << BL) + (PW'(hl_r) << AL)
                  + (PW'(hh_r) << (AL + BL));

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r   <= ll_nxt;
      lh_r   <= lh_nxt;
      hl_r   <= hl_nxt;
      hh_r   <= hh_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign res = prod_r[RW+FRAC_BITS-1:FRAC_BITS];
  assign hi  = |prod_r[PW-1:RW+FRAC_BITS];

endmodule

>>> hdl/lennard_jones_pair_energy_core.sv
// Lennard-Jones 12-6 pair energy in the well-minimum form. For each distance d the
// core returns epsilon * ((rmin/d)^12 - 2*(rmin/d)^6) as a signed 48-bit value with
// FRAC_BITS fraction bits; status is 1 when a power or the energy saturates and 2 for a
// zero distance. The core accepts one transaction every cycle unless the result side
// stalls, and delivers results in order. The bit-per-stage divider forming rmin/d comes
// first; five two-stage multipliers, a subtract stage and the output register follow.
// A stall on the result side holds the whole pipeline. Write rmin and epsilon only
// while no transaction is in flight.
module lennard_jones_pair_energy_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  lj_in_if.sink                             in_dist,
  lj_out_if.source                          out_res,
  input  logic                              cfg_we,
  input  logic [lj_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [lj_pkg::CFG_W-1:0]          cfg_data
);

  localparam int QW      = lj_pkg::CFG_W + FRAC_BITS;
  localparam int DIV_LAT = QW;
  localparam int MUL_LAT = 2;
  localparam int NMUL    = 5;
  localparam int PW      = lj_pkg::POW_W;
  localparam int MW      = lj_pkg::MAG_W;
  localparam int EW      = lj_pkg::ENERGY_W;

  logic                        en;
  logic [lj_pkg::CFG_W-1:0]    well_distance_r;
  logic [lj_pkg::CFG_W-1:0]    well_depth_r;

  lj_pkg::side_t               div_side_r [DIV_LAT];
  lj_pkg::side_t               div_side_nxt;
  lj_pkg::side_t               ms_r   [NMUL][MUL_LAT];
  lj_pkg::side_t               ms_in  [NMUL];
  lj_pkg::side_t               ms_fwd [NMUL-1];
  lj_pkg::side_t               diff_side_r;
  lj_pkg::side_t               diff_side_nxt;
  lj_pkg::side_t               fin_side;

  logic [QW-1:0]               quot;
  logic [PW-1:0]               q_ext;
  logic [PW-1:0]               mres [NMUL];
  logic [NMUL-1:0]             mhi;
  logic [PW-1:0]               p2d_r [MUL_LAT];
  logic [PW-1:0]               p6d_r [MUL_LAT];

  logic [MW:0]                 diff_pos;
  logic [MW:0]                 diff_neg;
  logic [MW-1:0]               mag_r;

  logic                        out_vld_r;
  logic signed [EW-1:0]        energy_r, energy_nxt;
  lj_pkg::status_t             status_r, status_nxt;

  // The pipeline advances unless a finished result is waiting to be taken.
  assign en            = !out_vld_r || out_res.ready;
  assign in_dist.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      well_distance_r <= lj_pkg::CFG_RESET;
      well_depth_r    <= lj_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (lj_pkg::cfg_idx_t'(cfg_idx))
        lj_pkg::REG_WELL_DISTANCE: well_distance_r <= cfg_data;
        lj_pkg::REG_WELL_DEPTH:    well_depth_r    <= cfg_data;
      endcase
    end
  end

  // Ratio rmin / d.
  lj_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .en      (en),
    .divisor (in_dist.distance),
    .rmin    (well_distance_r),
    .quot    (quot)
  );

  assign q_ext = PW'(quot);

  always_comb begin
    div_side_nxt      = '0;
    div_side_nxt.vld  = in_dist.valid;
    div_side_nxt.zero = (in_dist.distance == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        div_side_r[i] <= '0;
      end
    end else if (en) begin
      div_side_r[0] <= div_side_nxt;
      for (int i = 1; i < DIV_LAT; i++) begin
        div_side_r[i] <= div_side_r[i-1];
      end
    end
  end

  // Powers: p2 = q*q, p4 = p2*p2, p6 = p4*p2, p12 = p6*p6, then mag*epsilon.
  lj_mul #(.AW(PW), .BW(PW), .FRAC_BITS(FRAC_BITS)) u_mul_p2 (
    .clk (clk), .en (en), .a (q_ext), .b (q_ext), .res (mres[0]), .hi (mhi[0])
  );

  lj_mul #(.AW(PW), .BW(PW), .FRAC_BITS(FRAC_BITS)) u_mul_p4 (
    .clk (clk), .en (en), .a (mres[0]), .b (mres[0]), .res (mres[1]), .hi (mhi[1])
  );

  lj_mul #(.AW(PW), .BW(PW), .FRAC_BITS(FRAC_BITS)) u_mul_p6 (
    .clk (clk), .en (en), .a (mres[1]), .b (p2d_r[MUL_LAT-1]), .res (mres[2]),
    .hi  (mhi[2])
  );

  lj_mul #(.AW(PW), .BW(PW), .FRAC_BITS(FRAC_BITS)) u_mul_p12 (
    .clk (clk), .en (en), .a (mres[2]), .b (mres[2]), .res (mres[3]), .hi (mhi[3])
  );

  lj_mul #(.AW(MW), .BW(lj_pkg::CFG_W), .FRAC_BITS(FRAC_BITS)) u_mul_eps (
    .clk (clk), .en (en), .a (mag_r), .b (well_depth_r), .res (mres[4]), .hi (mhi[4])
  );

  // Overflow of any power is folded into the flags as it leaves its multiplier.
  always_comb begin
    for (int j = 0; j < NMUL - 1; j++) begin
      ms_fwd[j]     = ms_r[j][MUL_LAT-1];
      ms_fwd[j].ovf = ms_r[j][MUL_LAT-1].ovf | mhi[j];
    end
    ms_in[0] = div_side_r[DIV_LAT-1];
    for (int j = 1; j < NMUL - 1; j++) begin
      ms_in[j] = ms_fwd[j-1];
    end
    ms_in[NMUL-1] = diff_side_r;
    diff_side_nxt     = ms_fwd[NMUL-2];
    diff_side_nxt.neg = diff_pos[MW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NMUL; j++) begin
        for (int i = 0; i < MUL_LAT; i++) begin
          ms_r[j][i] <= '0;
        end
      end
      diff_side_r <= '0;
    end else if (en) begin
      for (int j = 0; j < NMUL; j++) begin
        ms_r[j][0] <= ms_in[j];
        for (int i = 1; i < MUL_LAT; i++) begin
          ms_r[j][i] <= ms_r[j][i-1];
        end
      end
      diff_side_r <= diff_side_nxt;
    end
  end

  // p2 waits beside the p4 multiplier, p6 beside the p12 multiplier.
  always_ff @(posedge clk) begin
    if (en) begin
      p2d_r[0] <= mres[0];
      p6d_r[0] <= mres[2];
      for (int i = 1; i < MUL_LAT; i++) begin
        p2d_r[i] <= p2d_r[i-1];
        p6d_r[i] <= p6d_r[i-1];
      end
    end
  end

  assign diff_pos = {2'b00, mres[3]} - {1'b0, p6d_r[MUL_LAT-1], 1'b0};
  assign diff_neg = {1'b0, p6d_r[MUL_LAT-1], 1'b0} - {2'b00, mres[3]};

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= diff_pos[MW] ? diff_neg[MW-1:0] : diff_pos[MW-1:0];
    end
  end

  assign fin_side = ms_r[NMUL-1][MUL_LAT-1];

  always_comb begin
    priority if (fin_side.zero) begin
      energy_nxt = lj_pkg::ENERGY_MAX;
      status_nxt = lj_pkg::ST_ZERO;
    end else if (fin_side.ovf) begin
      energy_nxt = lj_pkg::ENERGY_MAX;
      status_nxt = lj_pkg::ST_SAT;
    end else if (!fin_side.neg) begin
      if (mhi[4] || mres[4][EW-1]) begin
        energy_nxt = lj_pkg::ENERGY_MAX;
        status_nxt = lj_pkg::ST_SAT;
      end else begin
        energy_nxt = mres[4];
        status_nxt = lj_pkg::ST_OK;
      end
    end else begin
      // A magnitude of exactly 2^47 is still representable as a negative value.
      if (mhi[4] || (mres[4][EW-1] && (|mres[4][EW-2:0]))) begin
        energy_nxt = lj_pkg::ENERGY_MIN;
        status_nxt = lj_pkg::ST_SAT;
      end else begin
        energy_nxt = EW'(0) - mres[4];
        status_nxt = lj_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= fin_side.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      energy_r <= energy_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_res.valid  = out_vld_r;
  assign out_res.energy = energy_r;
  assign out_res.status = status_r;

endmodule

>>> dv/lennard_jones_pair_energy_core_test.sv
module lennard_jones_pair_energy_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;
  localparam int LATENCY = lj_pkg::CFG_W + FRAC_BITS + 12;
  localparam int STALL_CYCLES = 300;
  localparam bit [63:0] POW_CAP = 64'd1 << lj_pkg::POW_W;
  localparam bit [63:0] POS_ENERGY_CAP = 64'd1 << (lj_pkg::ENERGY_W - 1);
  localparam bit [63:0] NEG_ENERGY_CAP = (64'd1 << (lj_pkg::ENERGY_W - 1)) + 64'd1;

  typedef bit [lj_pkg::CFG_W-1:0] cfg_word_t;

  typedef struct {
    bit [lj_pkg::DIST_W-1:0]              distance;
    logic signed [lj_pkg::ENERGY_W-1:0]   energy;
    lj_pkg::status_t                      status;
  } pair_energy_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [lj_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [lj_pkg::CFG_W-1:0] cfg_data;

  lj_in_if dist_if();
  lj_out_if res_if();

  lennard_jones_pair_energy_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_dist (dist_if),
    .out_res (res_if),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  // Shadow copies of rmin and epsilon as last written.
  bit [lj_pkg::CFG_W-1:0] well_rmin;
  bit [lj_pkg::CFG_W-1:0] well_eps;

  pair_energy_t energy_expect_q[$];
  int mismatch_count;
  int src_idle_pct;
  int rcv_idle_pct;
  int stall_epoch;
  int stall_seen;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("lennard_jones_pair_energy_core_test failed");
    $finish;
  end

  // (a * b) >> FRAC_BITS on a full 128-bit product; false when the result reaches cap.
  function automatic bit scaled_product(input bit [63:0] a, input bit [63:0] b,
                                        input bit [63:0] cap, output bit [63:0] res);
    bit [127:0] full;
    full = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS;
    res = full[63:0];
    return full < {64'd0, cap};
  endfunction

  function automatic pair_energy_t predict_energy(input bit [lj_pkg::DIST_W-1:0] pair_dist);
    bit [63:0] ratio, p2, p4, p6, p12, mag, scaled;
    bit neg;
    pair_energy_t r;
    r.distance = pair_dist;
    if (pair_dist == 0) begin
      r.energy = lj_pkg::ENERGY_MAX;
      r.status = lj_pkg::ST_ZERO;
      return r;
    end
    ratio = ({40'd0, well_rmin} << FRAC_BITS) / {40'd0, pair_dist};
    if (!scaled_product(ratio, ratio, POW_CAP, p2) ||
        !scaled_product(p2, p2, POW_CAP, p4) ||
        !scaled_product(p4, p2, POW_CAP, p6) ||
        !scaled_product(p6, p6, POW_CAP, p12)) begin
      r.energy = lj_pkg::ENERGY_MAX;
      r.status = lj_pkg::ST_SAT;
      return r;
    end
    neg = p12 < 2 * p6;
    mag = neg ? 2 * p6 - p12 : p12 - 2 * p6;
    r.status = lj_pkg::ST_OK;
    if (!neg) begin
      if (!scaled_product(mag, {40'd0, well_eps}, POS_ENERGY_CAP, scaled)) begin
        r.energy = lj_pkg::ENERGY_MAX;
        r.status = lj_pkg::ST_SAT;
      end else begin
        r.energy = scaled[lj_pkg::ENERGY_W-1:0];
      end
    end else begin
      if (!scaled_product(mag, {40'd0, well_eps}, NEG_ENERGY_CAP, scaled)) begin
        r.energy = lj_pkg::ENERGY_MIN;
        r.status = lj_pkg::ST_SAT;
      end else begin
        r.energy = -scaled[lj_pkg::ENERGY_W-1:0];
      end
    end
    return r;
  endfunction

  // Most distances are scaled from rmin so that the curve, the zero crossing and the
  // overflow region all get exercised; the rest are full-field, small or edge values.
  function automatic bit [lj_pkg::DIST_W-1:0] random_distance();
    bit [35:0] span;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: span = ({12'd0, well_rmin} * $urandom_range(20, 1024)) >> 8;
      5, 6: span = {12'd0, 24'($urandom)};
      7: span = 36'($urandom_range(0, 255));
      8: begin
        case ($urandom_range(0, 3))
          0: span = '0;
          1: span = 36'd1;
          2: span = 36'hFFFFFF;
          default: span = {12'd0, well_rmin};
        endcase
      end
      default: span = ({12'd0, well_rmin} * $urandom_range(1, 50)) >> 8;
    endcase
    return (span > 36'hFFFFFF) ? 24'hFFFFFF : span[lj_pkg::DIST_W-1:0];
  endfunction

  function automatic bit [lj_pkg::CFG_W-1:0] random_setting(
      input bit [lj_pkg::CFG_W-1:0] lowest);
    case ($urandom_range(0, 4))
      0: return lowest;
      1: return 24'hFFFFFF;
      2: return cfg_word_t'($urandom_range(24'h004000, 24'h040000));
      default: return cfg_word_t'($urandom_range(lowest, 24'hFFFFFF));
    endcase
  endfunction

  task automatic send_distance(input bit [lj_pkg::DIST_W-1:0] pair_dist);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      dist_if.valid <= 1'b0;
      @(posedge clk);
    end
    dist_if.valid <= 1'b1;
    dist_if.distance <= pair_dist;
    do @(posedge clk); while (!dist_if.ready);
    energy_expect_q = {energy_expect_q, predict_energy(pair_dist)};
  endtask

  task automatic drain_results();
    dist_if.valid <= 1'b0;
    do @(posedge clk); while (energy_expect_q.size() != 0);
  endtask

  task automatic set_well(input bit [lj_pkg::CFG_W-1:0] rmin,
                          input bit [lj_pkg::CFG_W-1:0] eps);
    cfg_we <= 1'b1;
    cfg_idx <= lj_pkg::REG_WELL_DISTANCE;
    cfg_data <= rmin;
    @(posedge clk);
    cfg_idx <= lj_pkg::REG_WELL_DEPTH;
    cfg_data <= eps;
    @(posedge clk);
    cfg_we <= 1'b0;
    well_rmin = rmin;
    well_eps = eps;
  endtask

  task automatic test_reset_setting();
    bit [lj_pkg::DIST_W-1:0] dists[] = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h010000,
                                         24'h008000, 24'h00E412, 24'h002000, 24'h002A00,
                                         24'hAAAAAA, 24'h555555, 24'h018000};
    foreach (dists[i]) send_distance(dists[i]);
    drain_results();
  endtask

  task automatic test_extreme_settings();
    bit [lj_pkg::DIST_W-1:0] wide_dists[] = '{24'h2AAAAA, 24'hFFFFFF, 24'h000001,
                                              24'h800000};
    bit [lj_pkg::DIST_W-1:0] narrow_dists[] = '{24'h000001, 24'h000002, 24'hFFFFFF,
                                                24'h000000};
    set_well(24'hFFFFFF, 24'hFFFFFF);
    foreach (wide_dists[i]) send_distance(wide_dists[i]);
    drain_results();
    set_well(24'h000001, 24'h000000);
    foreach (narrow_dists[i]) send_distance(narrow_dists[i]);
    drain_results();
  endtask

  // With rmin at zero the ratio is zero and every nonzero distance gives zero energy.
  task automatic test_zero_well_distance();
    set_well(24'h000000, 24'hFFFFFF);
    send_distance(24'h000001);
    send_distance(24'h010000);
    send_distance(24'hFFFFFF);
    drain_results();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 59 : 0;
      rcv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 31 : 0;
      set_well(random_setting(24'h000001), random_setting(24'h000000));
      for (int n = 0; n < 90; n++) begin
        if (n == 45) begin
          drain_results();
          set_well(random_setting(24'h000001), random_setting(24'h000000));
        end
        send_distance(random_distance());
      end
      drain_results();
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill and push back on input.
  task automatic test_output_stall();
    set_well(24'h010000, cfg_word_t'($urandom_range(1, 24'hFFFFFF)));
    stall_epoch <= stall_epoch + 1;
    for (int n = 0; n < 100; n++) send_distance(random_distance());
    drain_results();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else if (stall_epoch != stall_seen) begin
      stall_seen <= stall_epoch;
      hold_left <= STALL_CYCLES;
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    pair_energy_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (energy_expect_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: energy %0d status %0d", res_if.energy,
                   res_if.status);
        mismatch_count++;
      end else begin
        want = energy_expect_q.pop_front();
        if (res_if.energy !== want.energy || res_if.status !== want.status) begin
          if (mismatch_count < 10)
            $display("distance %h: energy %0d status %0d, expected %0d status %0d",
                     want.distance, res_if.energy, res_if.status, want.energy,
                     want.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = lj_pkg::REG_WELL_DISTANCE;
    cfg_data = '0;
    dist_if.valid = 1'b0;
    dist_if.distance = '0;
    well_rmin = lj_pkg::CFG_RESET;
    well_eps = lj_pkg::CFG_RESET;
    src_idle_pct = 31;
    rcv_idle_pct = 59;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_setting();
    test_extreme_settings();
    test_zero_well_distance();
    test_random_traffic();
    test_output_stall();

    drain_results();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("lennard_jones_pair_energy_core_test passed");
    end else begin
      $display("lennard_jones_pair_energy_core_test failed");
    end
    $finish;
  end

endmodule
